### rtl/core/tsp_pkg.sv
// Shared types, codes and constants for the tone sequence player.
package tsp_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PLAY = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;
   localparam logic [1:0] OP_LOAD = 2'd3;

   localparam logic [7:0] LEN_HALT = 8'd0;
   localparam logic [7:0] LEN_LOOP = 8'd2;

   typedef enum logic [1:0] {
      TSP_IDLE,
      TSP_READ1,
      TSP_READ2,
      TSP_HOLD
   } tsp_state_type;

   typedef struct packed {
      logic        wr_en;
      logic [7:0]  wr_addr;
      logic [15:0] wr_data;
      logic        rd_en;
      logic [7:0]  rd_addr;
   } mem_req_type;

   function automatic logic mem_in_range(logic [7:0] addr);
      return int'(addr) < MEM_DEPTH;
   endfunction

endpackage

### rtl/core/tone_sequence_player.sv
// Top level of the tone sequence player: sequencer and tone memory.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | operation, start_index, entry_address,
//           |           |                       | entry_data
//   rsp     | out       | rsp_valid / rsp_stall | tone_period, tone_duty, drive_enable,
//           |           |                       | busy_res
//
// Load, stop and a tick that ends no note finish without a memory read; play and a
// note-ending tick do one tone memory read; following a repeat entry does a second.
// Reset clears all playback state; tone memory is not cleared.
// A stalled response holds; the next request is taken behind it, and its response
// waits in the sequencer until the response register frees.
module tone_sequence_player (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_start_index,
   input  logic [7:0]  req_entry_address,
   input  logic [15:0] req_entry_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tone_period,
   output logic [6:0]  rsp_tone_duty,
   output logic        rsp_drive_enable,
   output logic        rsp_busy_res
);
   import tsp_pkg::*;

   mem_req_type mem_req;
   logic [15:0] rd_data;

   tsp_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_start_index   (req_start_index),
      .req_entry_address (req_entry_address),
      .req_entry_data    (req_entry_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tone_period   (rsp_tone_period),
      .rsp_tone_duty     (rsp_tone_duty),
      .rsp_drive_enable  (rsp_drive_enable),
      .rsp_busy_res      (rsp_busy_res),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   tsp_tone_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

### rtl/core/tsp_tone_ram.sv
// Tone memory: one write and one registered read per cycle.
module tsp_tone_ram (
   input  logic                clock,
   input  tsp_pkg::mem_req_type mem_req,
   output logic [15:0]         rd_data
);
   import tsp_pkg::*;

   logic [15:0] mem [MEM_DEPTH];
   logic [15:0] rd_q_ff;
   logic        rd_hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en && mem_in_range(mem_req.wr_addr)) begin
         mem[MEM_AW'(mem_req.wr_addr)] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_q_ff   <= mem[MEM_AW'(mem_req.rd_addr)];
         rd_hit_ff <= mem_in_range(mem_req.rd_addr);
      end
   end

   // out-of-range reads return a stop entry
   assign rd_data = rd_hit_ff ? rd_q_ff : 16'h0000;

endmodule

### rtl/core/tsp_seq.sv
// Playback sequencer: request decode, note state and response register.
module tsp_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [7:0]           req_start_index,
   input  logic [7:0]           req_entry_address,
   input  logic [15:0]          req_entry_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tone_period,
   output logic [6:0]           rsp_tone_duty,
   output logic                 rsp_drive_enable,
   output logic                 rsp_busy_res,
   output tsp_pkg::mem_req_type mem_req,
   input  logic [15:0]          rd_data
);
   import tsp_pkg::*;

   tsp_state_type state_ff, state_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] tune_start_ff, tune_start_in;
   logic [7:0] elapsed_ff, elapsed_in;
   logic [7:0] note_len_ff, note_len_in;
   logic       playing_ff, playing_in;
   logic [7:0] period_ff, period_in;
   logic       enable_ff, enable_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_period_ff;
   logic       rsp_enable_ff;
   logic       rsp_busy_ff;

   logic finish;
   logic slot_free;
   logic emit;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != TSP_IDLE);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      tune_start_in = tune_start_ff;
      elapsed_in    = elapsed_ff;
      note_len_in   = note_len_ff;
      playing_in    = playing_ff;
      period_in     = period_ff;
      enable_in     = enable_ff;
      mem_req       = '0;
      finish        = 1'b0;

      case (state_ff)
         TSP_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_TICK: begin
                     if (playing_ff) begin
                        if (elapsed_ff != 8'hFF) begin
                           elapsed_in = elapsed_ff + 8'd1;
                        end
                        if (elapsed_in >= note_len_ff) begin
                           mem_req.rd_en   = 1'b1;
                           mem_req.rd_addr = pos_ff;
                           pos_in          = pos_ff + 8'd1;
                           state_in        = TSP_READ1;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  OP_PLAY: begin
                     tune_start_in   = req_start_index;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = req_start_index;
                     pos_in          = req_start_index + 8'd1;
                     state_in        = TSP_READ1;
                  end
                  OP_STOP: begin
                     period_in   = 8'd0;
                     elapsed_in  = 8'd0;
                     note_len_in = 8'd0;
                     playing_in  = 1'b0;
                     enable_in   = 1'b0;
                     finish      = 1'b1;
                  end
                  default: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_entry_address;
                     mem_req.wr_data = req_entry_data;
                     finish          = 1'b1;
                  end
               endcase
            end
         end
         TSP_READ1: begin
            if (rd_data[7:0] == LEN_LOOP) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = tune_start_ff;
               pos_in          = tune_start_ff + 8'd1;
               state_in        = TSP_READ2;
            end else begin
               period_in   = rd_data[15:8];
               elapsed_in  = 8'd0;
               note_len_in = rd_data[7:0];
               playing_in  = (rd_data[7:0] != LEN_HALT);
               enable_in   = (rd_data[7:0] != LEN_HALT);
               finish      = 1'b1;
            end
         end
         TSP_READ2: begin
            // repeat landing on a repeat halts playback
            if (rd_data[7:0] == LEN_LOOP) begin
               playing_in = 1'b0;
               enable_in  = 1'b0;
            end else begin
               period_in   = rd_data[15:8];
               elapsed_in  = 8'd0;
               note_len_in = rd_data[7:0];
               playing_in  = (rd_data[7:0] != LEN_HALT);
               enable_in   = (rd_data[7:0] != LEN_HALT);
            end
            finish = 1'b1;
         end
         TSP_HOLD: begin
            finish = 1'b0;
         end
         default: begin
            state_in = TSP_IDLE;
         end
      endcase

      emit = (finish || (state_ff == TSP_HOLD)) && slot_free;
      if (finish || (state_ff == TSP_HOLD)) begin
         state_in = slot_free ? TSP_IDLE : TSP_HOLD;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= TSP_IDLE;
         pos_ff        <= 8'd0;
         tune_start_ff <= 8'd0;
         elapsed_ff    <= 8'd0;
         note_len_ff   <= 8'd0;
         playing_ff    <= 1'b0;
         period_ff     <= 8'd0;
         enable_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         tune_start_ff <= tune_start_in;
         elapsed_ff    <= elapsed_in;
         note_len_ff   <= note_len_in;
         playing_ff    <= playing_in;
         period_ff     <= period_in;
         enable_ff     <= enable_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_period_ff <= period_in;
         rsp_enable_ff <= enable_in;
         rsp_busy_ff   <= playing_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone_period  = rsp_period_ff;
   assign rsp_tone_duty    = rsp_period_ff[7:1];
   assign rsp_drive_enable = rsp_enable_ff;
   assign rsp_busy_res     = rsp_busy_ff;

endmodule
